// File: rtl/lmsf_pkg.sv
// Shared types and constants for the LMS adaptive FIR filter.
// Used by lms_adaptive_fir and its testbench; depends on nothing.
package lmsf_pkg;

    localparam int SAMPLE_W  = 16;   // Q1.15 samples
    localparam int WEIGHT_W  = 32;   // Q4.28 weights
    localparam int STEP_W    = 16;   // Q0.16 step
    localparam int INDEX_W   = 8;    // tap_index field
    localparam int GE_W      = 33;   // step * error, signed
    localparam int PROD_W    = GE_W + SAMPLE_W;
    localparam int OUT_SHIFT = 28;   // Q5.43 sum -> Q1.15
    localparam int UPD_SHIFT = 18;   // Q2.46 delta -> Q4.28

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd524;

    typedef enum logic [1:0] {
        REQ_ADAPT  = 2'd0,
        REQ_FILTER = 2'd1,
        REQ_READ   = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_FIR,
        ST_FIR_DRAIN,
        ST_Y,
        ST_E,
        ST_GE,
        ST_GE_WAIT,
        ST_UPD,
        ST_UPD_DRAIN,
        ST_CLR,
        ST_RD,
        ST_DONE
    } state_t;

endpackage

// File: rtl/lmsf_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// Holds the delay line and the tap weights; no package dependency.
module lmsf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/lms_adaptive_fir.sv
// LMS adaptive FIR filter top level: sequencer, shared multiplier, accumulator.
// Depends on lmsf_pkg and lmsf_ram.
//
// One input word at a time. An adapt item makes a FIR pass and an update pass,
// each streaming TAPS entries through the one 33x16 signed multiplier at one tap
// per cycle with a pipeline drain after each pass, plus rounding, the error, the
// step*error product and the return to idle. Filter-only items make only the FIR
// pass, and clear-delay-line items make one RAM write per cycle. After reset both
// RAMs are cleared, with s_tready low. The delay line is a circular buffer, so a
// new sample costs a single write. A finished result sits in the output register,
// so the block goes back to idle while the previous result waits for m_tready.
module lms_adaptive_fir #(
    parameter int TAPS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // adaptation step mu, unsigned Q0.16
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] desired_sample, [31:16] reference_sample, [39:32] tap_index,
    // [47:40] zero
    input  logic [47:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_tuser,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] filter_output, [31:16] error_value, [63:32] weight_value
    output logic [63:0] m_tdata
);

    localparam int AW    = $clog2(TAPS);
    localparam int ACC_W = lmsf_pkg::SAMPLE_W + lmsf_pkg::WEIGHT_W + AW;
    localparam int Q_W   = ACC_W - lmsf_pkg::OUT_SHIFT;
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    lmsf_pkg::state_t state_reg, state_next;
    lmsf_pkg::req_t   mode_reg;

    logic [lmsf_pkg::STEP_W-1:0] step_reg;
    logic [AW-1:0]               cnt_reg;
    logic [AW-1:0]               ptr_reg;
    logic [AW-1:0]               head_reg;
    logic [AW-1:0]               wa1_reg, wa2_reg;
    logic                        v1_reg, v2_reg;
    logic                        upd_pass_reg;
    logic                        rd_ok_reg;

    logic signed [15:0]          desired_reg;
    logic signed [15:0]          y_reg;
    logic signed [15:0]          e_reg;
    logic signed [31:0]          wv_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [lmsf_pkg::GE_W-1:0]   ge_reg;
    logic signed [lmsf_pkg::PROD_W-1:0] prod_reg;
    logic signed [31:0]          wpipe_reg;

    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;

    // ---------------------------------------------------------------
    // Input word fields
    // ---------------------------------------------------------------
    logic                 s_acc;
    lmsf_pkg::req_t       s_req;
    logic [15:0]          s_desired;
    logic [15:0]          s_reference;
    logic [7:0]           s_index;
    logic [AW+7:0]        s_index_ext;
    logic [AW-1:0]        s_index_addr;
    logic                 s_index_ok;
    logic [AW-1:0]        head_next;

    assign s_req        = lmsf_pkg::req_t'(s_tuser[1:0]);
    assign s_desired    = s_tdata[15:0];
    assign s_reference  = s_tdata[31:16];
    assign s_index      = s_tdata[39:32];
    assign s_index_ext  = (AW + 8)'(s_index);
    assign s_index_addr = s_index_ext[AW-1:0];
    assign s_index_ok   = ({24'd0, s_index} < 32'(TAPS));
    assign s_tready     = (state_reg == lmsf_pkg::ST_IDLE);
    assign s_acc        = s_tvalid && s_tready;
    // step the head back one slot: the newest sample sits at position 0
    assign head_next    = (head_reg == '0) ? LAST : head_reg - 1'b1;

    // ---------------------------------------------------------------
    // RAMs
    // ---------------------------------------------------------------
    logic          dl_we, w_we;
    logic [AW-1:0] dl_waddr, w_waddr, w_raddr;
    logic [15:0]   dl_wdata, dl_rdata;
    logic [31:0]   w_wdata, w_rdata;
    logic          new_sample;

    assign new_sample = s_acc &&
                        (s_req == lmsf_pkg::REQ_ADAPT || s_req == lmsf_pkg::REQ_FILTER);

    always_comb begin
        dl_we    = new_sample || state_reg == lmsf_pkg::ST_INIT
                              || state_reg == lmsf_pkg::ST_CLR;
        dl_waddr = new_sample ? head_next : cnt_reg;
        dl_wdata = new_sample ? s_reference : 16'd0;
    end

    lmsf_ram #(
        .WIDTH(lmsf_pkg::SAMPLE_W),
        .DEPTH(TAPS)
    ) u_delay (
        .aclk (aclk),
        .we   (dl_we),
        .waddr(dl_waddr),
        .wdata(dl_wdata),
        .raddr(ptr_reg),
        .rdata(dl_rdata)
    );

    // weight update: round the Q2.46 delta to Q4.28, add, saturate
    logic signed [lmsf_pkg::PROD_W-1:0] delta_round;
    logic signed [lmsf_pkg::PROD_W-lmsf_pkg::UPD_SHIFT-1:0] delta;
    logic signed [32:0] w_sum;
    logic [31:0]        w_new;

    always_comb begin
        delta_round = prod_reg + lmsf_pkg::PROD_W'(1 << (lmsf_pkg::UPD_SHIFT - 1));
        delta       = delta_round[lmsf_pkg::PROD_W-1:lmsf_pkg::UPD_SHIFT];
        w_sum       = 33'(wpipe_reg) + 33'(delta);
        if (w_sum > 33'sh0_7FFF_FFFF) begin
            w_new = 32'h7FFF_FFFF;
        end else if (w_sum < -33'sh0_8000_0000) begin
            w_new = 32'h8000_0000;
        end else begin
            w_new = w_sum[31:0];
        end
    end

    always_comb begin
        w_we    = (state_reg == lmsf_pkg::ST_INIT) || (v2_reg && upd_pass_reg);
        w_waddr = (state_reg == lmsf_pkg::ST_INIT) ? cnt_reg : wa2_reg;
        w_wdata = (state_reg == lmsf_pkg::ST_INIT) ? 32'd0 : w_new;
        w_raddr = (state_reg == lmsf_pkg::ST_IDLE) ? s_index_addr : cnt_reg;
    end

    lmsf_ram #(
        .WIDTH(lmsf_pkg::WEIGHT_W),
        .DEPTH(TAPS)
    ) u_weight (
        .aclk (aclk),
        .we   (w_we),
        .waddr(w_waddr),
        .wdata(w_wdata),
        .raddr(w_raddr),
        .rdata(w_rdata)
    );

    // ---------------------------------------------------------------
    // Shared multiplier: weight*sample, step*error, (step*error)*sample
    // ---------------------------------------------------------------
    logic signed [lmsf_pkg::GE_W-1:0]     mul_a;
    logic signed [lmsf_pkg::SAMPLE_W-1:0] mul_b;

    always_comb begin
        if (state_reg == lmsf_pkg::ST_GE) begin
            mul_a = signed'({17'd0, step_reg});
            mul_b = e_reg;
        end else if (upd_pass_reg) begin
            mul_a = ge_reg;
            mul_b = signed'(dl_rdata);
        end else begin
            mul_a = lmsf_pkg::GE_W'(signed'(w_rdata));
            mul_b = signed'(dl_rdata);
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg  <= lmsf_pkg::PROD_W'(mul_a) * lmsf_pkg::PROD_W'(mul_b);
        wpipe_reg <= signed'(w_rdata);
        wa1_reg   <= cnt_reg;
        wa2_reg   <= wa1_reg;
    end

    // ---------------------------------------------------------------
    // Output rounding and error
    // ---------------------------------------------------------------
    logic signed [ACC_W-1:0] acc_round;
    logic signed [Q_W-1:0]   y_q;
    logic signed [15:0]      y_sat;
    logic signed [16:0]      e_diff;
    logic signed [15:0]      e_sat;

    always_comb begin
        acc_round = acc_reg + ACC_W'(1 << (lmsf_pkg::OUT_SHIFT - 1));
        y_q       = acc_round[ACC_W-1:lmsf_pkg::OUT_SHIFT];
        if (y_q > Q_W'(32767)) begin
            y_sat = 16'sh7FFF;
        end else if (y_q < -Q_W'(32768)) begin
            y_sat = -16'sh8000;
        end else begin
            y_sat = y_q[15:0];
        end
        e_diff = 17'(desired_reg) - 17'(y_reg);
        if (e_diff > 17'sd32767) begin
            e_sat = 16'sh7FFF;
        end else if (e_diff < -17'sd32768) begin
            e_sat = -16'sh8000;
        end else begin
            e_sat = e_diff[15:0];
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    logic out_load;
    assign out_load = (state_reg == lmsf_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lmsf_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lmsf_pkg::ST_INIT: begin
                if (cnt_reg == LAST) begin
                    state_next = lmsf_pkg::ST_IDLE;
                end
            end
            lmsf_pkg::ST_IDLE: begin
                if (s_acc) begin
                    unique case (s_req)
                        lmsf_pkg::REQ_ADAPT,
                        lmsf_pkg::REQ_FILTER: state_next = lmsf_pkg::ST_FIR;
                        lmsf_pkg::REQ_READ:   state_next = lmsf_pkg::ST_RD;
                        lmsf_pkg::REQ_CLEAR:  state_next = lmsf_pkg::ST_CLR;
                        default:              state_next = lmsf_pkg::ST_IDLE;
                    endcase
                end
            end
            lmsf_pkg::ST_FIR: begin
                if (cnt_reg == LAST) begin
                    state_next = lmsf_pkg::ST_FIR_DRAIN;
                end
            end
            lmsf_pkg::ST_FIR_DRAIN: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = lmsf_pkg::ST_Y;
                end
            end
            lmsf_pkg::ST_Y: state_next = lmsf_pkg::ST_E;
            lmsf_pkg::ST_E: begin
                state_next = (mode_reg == lmsf_pkg::REQ_ADAPT) ? lmsf_pkg::ST_GE
                                                               : lmsf_pkg::ST_DONE;
            end
            lmsf_pkg::ST_GE:      state_next = lmsf_pkg::ST_GE_WAIT;
            lmsf_pkg::ST_GE_WAIT: state_next = lmsf_pkg::ST_UPD;
            lmsf_pkg::ST_UPD: begin
                if (cnt_reg == LAST) begin
                    state_next = lmsf_pkg::ST_UPD_DRAIN;
                end
            end
            lmsf_pkg::ST_UPD_DRAIN: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = lmsf_pkg::ST_DONE;
                end
            end
            lmsf_pkg::ST_CLR: begin
                if (cnt_reg == LAST) begin
                    state_next = lmsf_pkg::ST_DONE;
                end
            end
            lmsf_pkg::ST_RD: state_next = lmsf_pkg::ST_DONE;
            lmsf_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = lmsf_pkg::ST_IDLE;
                end
            end
            default: state_next = lmsf_pkg::ST_INIT;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= lmsf_pkg::STEP_RESET;
            cnt_reg      <= '0;
            ptr_reg      <= '0;
            head_reg     <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            upd_pass_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                step_reg <= cfg_wr_data;
            end
            v1_reg <= (state_reg == lmsf_pkg::ST_FIR) || (state_reg == lmsf_pkg::ST_UPD);
            v2_reg <= v1_reg;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                lmsf_pkg::ST_INIT, lmsf_pkg::ST_CLR: begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                lmsf_pkg::ST_IDLE: begin
                    if (s_acc) begin
                        cnt_reg      <= '0;
                        upd_pass_reg <= 1'b0;
                        ptr_reg      <= head_next;
                        if (new_sample) begin
                            head_reg <= head_next;
                        end
                    end
                end
                lmsf_pkg::ST_FIR, lmsf_pkg::ST_UPD: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    ptr_reg <= (ptr_reg == LAST) ? '0 : ptr_reg + 1'b1;
                end
                lmsf_pkg::ST_GE_WAIT: begin
                    // rewind for the update pass over the same window
                    cnt_reg      <= '0;
                    ptr_reg      <= head_reg;
                    upd_pass_reg <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (v2_reg && !upd_pass_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (out_load) begin
            m_tdata_reg <= {wv_reg, e_reg, y_reg};
        end
        case (state_reg)
            lmsf_pkg::ST_IDLE: begin
                if (s_acc) begin
                    mode_reg    <= s_req;
                    desired_reg <= signed'(s_desired);
                    rd_ok_reg   <= s_index_ok;
                    acc_reg     <= '0;
                    y_reg       <= '0;
                    e_reg       <= '0;
                    wv_reg      <= '0;
                end
            end
            lmsf_pkg::ST_Y: y_reg <= y_sat;
            lmsf_pkg::ST_E: begin
                if (mode_reg == lmsf_pkg::REQ_ADAPT) begin
                    e_reg <= e_sat;
                end
            end
            lmsf_pkg::ST_GE_WAIT: ge_reg <= prod_reg[lmsf_pkg::GE_W-1:0];
            lmsf_pkg::ST_RD: wv_reg <= rd_ok_reg ? signed'(w_rdata) : 32'sd0;
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // rounding must see the sum only after the pipeline has emptied
    a_fir_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lmsf_pkg::ST_Y) |-> (!v1_reg && !v2_reg))
        else $error("FIR sum rounded before pipeline drained");

    // a read request goes straight to the read-data state
    a_read_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_req == lmsf_pkg::REQ_READ) |=> (state_reg == lmsf_pkg::ST_RD))
        else $error("read request did not enter read state");

    // a clear item reports all-zero fields
    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lmsf_pkg::ST_DONE && mode_reg == lmsf_pkg::REQ_CLEAR)
            |-> (y_reg == 16'sd0 && e_reg == 16'sd0 && wv_reg == 32'sd0))
        else $error("clear item result not zero");

    // weights change only during init or the update pass
    a_weight_write: assert property (@(posedge aclk) disable iff (!aresetn)
        w_we |-> (state_reg == lmsf_pkg::ST_INIT || mode_reg == lmsf_pkg::REQ_ADAPT))
        else $error("weight write outside adapt item");
`endif

endmodule

// File: tb/sv/lms_adaptive_fir_tb.sv
// Self-checking testbench for lms_adaptive_fir: a queue-fed stream driver, a result monitor
// and a cycle-free LMS predictor that tracks delay line, weights and step size.
// Depends on lmsf_pkg and the lms_adaptive_fir RTL.
module lms_adaptive_fir_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS = 256;

    // One input word as the sender sees it.
    typedef struct packed {
        lmsf_pkg::req_t                       req;
        logic signed [lmsf_pkg::SAMPLE_W-1:0] desired;
        logic signed [lmsf_pkg::SAMPLE_W-1:0] reference;
        logic [lmsf_pkg::INDEX_W-1:0]         tap_index;
    } lms_word_t;

    // One result word.
    typedef struct packed {
        logic signed [lmsf_pkg::SAMPLE_W-1:0] filter_output;
        logic signed [lmsf_pkg::SAMPLE_W-1:0] error_value;
        logic signed [lmsf_pkg::WEIGHT_W-1:0] weight_value;
    } lms_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;  // [15:0] desired, [31:16] reference, [39:32] tap_index, zero
    logic [1:0]  s_tuser = '0;  // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;       // [15:0] filter_output, [31:16] error_value, [63:32] weight

    lms_adaptive_fir #(
        .TAPS(TAPS)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #4 aclk = ~aclk;

    // Predictor state: delay line (newest at 0), Q4.28 weights, Q0.16 step.
    logic signed [lmsf_pkg::SAMPLE_W-1:0] hist [TAPS];
    logic signed [lmsf_pkg::WEIGHT_W-1:0] coef [TAPS];
    logic [lmsf_pkg::STEP_W-1:0]          step_mu = lmsf_pkg::STEP_RESET;

    lms_word_t   sample_word_q [$];   // words waiting for the driver
    lms_result_t lms_result_q [$];    // predicted results, oldest first

    int          fail_count = 0;
    int          idle_odds = 0;       // percent chance to open an idle burst
    int          src_gap = 0;
    int          sink_gap = 0;
    bit          word_taken = 1'b0;
    lms_word_t   next_word;
    lms_word_t   seen_word;
    lms_result_t got_result;
    lms_result_t want_result;
    lms_result_t new_result;

    initial begin
        for (int i = 0; i < TAPS; i++) begin
            hist[i] = '0;
            coef[i] = '0;
        end
    end

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the predicted filter by one word and return the result it gives.
    task automatic step_lms(input lms_word_t w, output lms_result_t r);
        longint acc;
        longint y;
        longint e;
        longint ge;
        longint d;
        longint nw;
        r = '0;
        case (w.req)
            lmsf_pkg::REQ_ADAPT, lmsf_pkg::REQ_FILTER: begin
                for (int i = TAPS - 1; i > 0; i--)
                    hist[i] = hist[i-1];
                hist[0] = w.reference;
                acc = 0;
                for (int i = 0; i < TAPS; i++)
                    acc += longint'(coef[i]) * longint'(hist[i]);
                // Round Q5.43 to Q1.15; >>> on a signed longint floors.
                y = (acc + (longint'(1) << (lmsf_pkg::OUT_SHIFT - 1))) >>> lmsf_pkg::OUT_SHIFT;
                y = sat(y, -32768, 32767);
                r.filter_output = y[lmsf_pkg::SAMPLE_W-1:0];
                if (w.req == lmsf_pkg::REQ_ADAPT) begin
                    e = sat(longint'($signed(w.desired)) - y, -32768, 32767);
                    r.error_value = e[lmsf_pkg::SAMPLE_W-1:0];
                    ge = longint'(step_mu) * e;
                    // Update uses the shifted history and the old weights.
                    for (int i = 0; i < TAPS; i++) begin
                        d = (ge * longint'(hist[i])
                             + (longint'(1) << (lmsf_pkg::UPD_SHIFT - 1)))
                            >>> lmsf_pkg::UPD_SHIFT;
                        nw = sat(longint'(coef[i]) + d, -64'sd2147483648, 64'sd2147483647);
                        coef[i] = nw[lmsf_pkg::WEIGHT_W-1:0];
                    end
                end
            end
            lmsf_pkg::REQ_READ: begin
                if (w.tap_index < TAPS)
                    r.weight_value = coef[w.tap_index];
            end
            default: begin
                // Clear the history only; weights keep their values.
                for (int i = 0; i < TAPS; i++)
                    hist[i] = '0;
            end
        endcase
    endtask

    // Sample both handshakes at the rising edge: predict on accept, check on result.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                seen_word.req       = lmsf_pkg::req_t'(s_tuser);
                seen_word.desired   = s_tdata[15:0];
                seen_word.reference = s_tdata[31:16];
                seen_word.tap_index = s_tdata[39:32];
                step_lms(seen_word, new_result);
                lms_result_q.push_back(new_result);
                word_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                got_result.filter_output = m_tdata[15:0];
                got_result.error_value   = m_tdata[31:16];
                got_result.weight_value  = m_tdata[63:32];
                if (lms_result_q.size() == 0) begin
                    $error("result word with nothing expected: %h", m_tdata);
                    fail_count++;
                end else begin
                    want_result = lms_result_q.pop_front();
                    if (got_result.filter_output !== want_result.filter_output) begin
                        $error("filter_output: expected %0d, got %0d",
                               want_result.filter_output, got_result.filter_output);
                        fail_count++;
                    end
                    if (got_result.error_value !== want_result.error_value) begin
                        $error("error_value: expected %0d, got %0d",
                               want_result.error_value, got_result.error_value);
                        fail_count++;
                    end
                    if (got_result.weight_value !== want_result.weight_value) begin
                        $error("weight_value: expected %0d, got %0d",
                               want_result.weight_value, got_result.weight_value);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Input driver: change at the falling edge, hold a word until it is taken,
    // and drop tvalid for random idle bursts.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            word_taken = 1'b0;
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (sample_word_q.size() != 0 && idle_odds != 0 &&
                         $urandom_range(0, 99) < idle_odds) begin
                src_gap = $urandom_range(1, 5) - 1;
                s_tvalid <= 1'b0;
            end else if (sample_word_q.size() != 0) begin
                next_word = sample_word_q.pop_front();
                s_tdata  <= {8'h00, next_word.tap_index, next_word.reference,
                             next_word.desired};
                s_tuser  <= next_word.req;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result-side back-pressure: stall in random bursts.
    always @(negedge aclk) begin
        if (sink_gap > 0) begin
            sink_gap--;
            m_tready <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
            sink_gap = $urandom_range(1, 5) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic lms_word_t mk_word(input lmsf_pkg::req_t req,
                                          input logic [15:0] desired,
                                          input logic [15:0] reference,
                                          input logic [7:0] tap_index);
        lms_word_t w;
        w.req       = req;
        w.desired   = desired;
        w.reference = reference;
        w.tap_index = tap_index;
        return w;
    endfunction

    // Mix full-scale, small, mid and rail values so both saturation and
    // linear behavior get exercised.
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 1023)) - 16'd512;
            2:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(0, 16383)) - 16'd8192;
        endcase
    endfunction

    task automatic queue_random(input int n);
        int             pick;
        lmsf_pkg::req_t req;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                req = lmsf_pkg::REQ_ADAPT;
            else if (pick < 75)
                req = lmsf_pkg::REQ_FILTER;
            else if (pick < 91)
                req = lmsf_pkg::REQ_READ;
            else
                req = lmsf_pkg::REQ_CLEAR;
            sample_word_q.push_back(mk_word(req, rand_sample(), rand_sample(),
                                            8'($urandom_range(0, 255))));
        end
    endtask

    // Hold until every queued word is sent, every result is back and the block
    // is ready for a new word again.
    task automatic wait_drained();
        @(negedge aclk);
        while (sample_word_q.size() != 0 || s_tvalid || lms_result_q.size() != 0 ||
               !s_tready)
            @(negedge aclk);
    endtask

    // Write the step register while idle and track it in the predictor.
    task automatic write_step(input logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        step_mu      = value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset step: reads of zero weights, rail samples, clear with junk fields.
        idle_odds = 20;
        sample_word_q.push_back(mk_word(lmsf_pkg::REQ_READ, 16'h5a5a, 16'ha5a5, 8'd0));
        sample_word_q.push_back(mk_word(lmsf_pkg::REQ_ADAPT, 16'h7fff, 16'h7fff, 8'hff));
        sample_word_q.push_back(mk_word(lmsf_pkg::REQ_ADAPT, 16'h8000, 16'h8000, 8'h00));
        sample_word_q.push_back(mk_word(lmsf_pkg::REQ_FILTER, 16'h5555, 16'h7fff, 8'haa));
        sample_word_q.push_back(mk_word(lmsf_pkg::REQ_READ, 16'h0000, 16'h0000, 8'd0));
        sample_word_q.push_back(mk_word(lmsf_pkg::REQ_READ, 16'hffff, 16'hffff, 8'd255));
        sample_word_q.push_back(mk_word(lmsf_pkg::REQ_READ, 16'h0000, 16'h0000, 8'd1));
        sample_word_q.push_back(mk_word(lmsf_pkg::REQ_CLEAR, 16'h1234, 16'h04d2, 8'h55));
        sample_word_q.push_back(mk_word(lmsf_pkg::REQ_FILTER, 16'h0000, 16'h0000, 8'd0));
        sample_word_q.push_back(mk_word(lmsf_pkg::REQ_ADAPT, 16'hffff, 16'h0001, 8'd0));
        sample_word_q.push_back(mk_word(lmsf_pkg::REQ_READ, 16'h0000, 16'h0000, 8'd0));
        sample_word_q.push_back(mk_word(lmsf_pkg::REQ_ADAPT, 16'h0000, 16'h0000, 8'd0));
        wait_drained();

        // Largest step: drive weights and output into saturation, then force
        // error saturation in both directions from a cleared history.
        write_step(16'hffff);
        idle_odds = 30;
        repeat (8)
            sample_word_q.push_back(mk_word(lmsf_pkg::REQ_ADAPT, 16'h7fff, 16'h7fff, 8'd0));
        sample_word_q.push_back(mk_word(lmsf_pkg::REQ_READ, 16'h0000, 16'h0000, 8'd0));
        sample_word_q.push_back(mk_word(lmsf_pkg::REQ_CLEAR, 16'h0000, 16'h0000, 8'd0));
        sample_word_q.push_back(mk_word(lmsf_pkg::REQ_ADAPT, 16'h7fff, 16'h8000, 8'd0));
        sample_word_q.push_back(mk_word(lmsf_pkg::REQ_CLEAR, 16'h0000, 16'h0000, 8'd0));
        sample_word_q.push_back(mk_word(lmsf_pkg::REQ_ADAPT, 16'h8000, 16'h7fff, 8'd0));
        queue_random(200);
        wait_drained();

        // Zero step: weights freeze; run without any idling.
        write_step(16'h0000);
        idle_odds = 0;
        queue_random(150);
        wait_drained();

        write_step(16'($urandom_range(1, 65534)));
        idle_odds = 40;
        queue_random(250);
        wait_drained();

        write_step(16'h0001);
        idle_odds = 20;
        queue_random(100);
        wait_drained();

        // Back to the default step; the last stretch runs with no idling.
        write_step(lmsf_pkg::STEP_RESET);
        idle_odds = 20;
        queue_random(150);
        wait_drained();
        idle_odds = 0;
        queue_random(150);
        wait_drained();

        // Let a full adapt pass go by to catch any stray result word.
        repeat (600) @(negedge aclk);
        if (lms_result_q.size() != 0) begin
            $error("%0d expected result words never arrived", lms_result_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("PASS lms_adaptive_fir");
        else
            $display("FAIL lms_adaptive_fir");
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial begin
        #25_000_000;
        $display("FAIL lms_adaptive_fir");
        $finish;
    end

endmodule
